[rtl/register_map_with_atomic_write_top_assert.svh]
// Assertion macros for the register map RTL; rmaw_back uses them.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef REGISTER_MAP_WITH_ATOMIC_WRITE_TOP_ASSERT_SVH
`define REGISTER_MAP_WITH_ATOMIC_WRITE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RMAW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RMAW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RMAW_ASSERT_IMP(lbl, ante, cons, msg)
`define RMAW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/rmaw_pkg.sv]
`default_nettype none

package rmaw_pkg;

	localparam int INPUT_COUNT_DEF = 12;
	localparam int HOLDING_COUNT_DEF = 4;
	localparam logic [15:0] HOLD_WORD0_RESET = 16'd1000;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] TBL_INPUT = 2'd0;
	localparam logic [1:0] TBL_HOLDING = 2'd1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_TABLE = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_BAD_VALUE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_STATUS = 2'd1,
		OP_READ = 2'd2,
		OP_BURST = 2'd3
	} op_kind_t;

	// One classified operation as it travels from the front end to the back end.
	typedef struct packed {
		op_kind_t kind;
		status_t status;
		logic holding;
		logic [15:0] address;
		logic [15:0] count;
		logic [15:0] value;
		logic last;
	} op_t;

endpackage

`default_nettype wire

[rtl/register_map_with_atomic_write_top.sv]
// Channel   Direction  Handshake          Fields
// in        into block in_valid/in_stall  command, table_sel, address, count, value, last_word
// out       from block out_valid/out_stall status, data, last_of_run
//
// An item enters a two-entry queue in the cycle it is transferred, so the input side keeps
// moving while the back end works. Updates and status-only results are emitted when taken.
// A read takes an issue state and an emit state per word, set by the registered read port
// of the store; a good write burst commits one word per cycle through the staging buffer.
// Reset clears the queue, the burst state and the store valid bits at once.
// A stall on the output holds the result register and backs up through the queue.
`default_nettype none

module register_map_with_atomic_write_top #(
	parameter int INPUT_COUNT = rmaw_pkg::INPUT_COUNT_DEF,
	parameter int HOLDING_COUNT = rmaw_pkg::HOLDING_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] command,
	input wire logic [1:0] table_sel,
	input wire logic [15:0] address,
	input wire logic [15:0] count,
	input wire logic [15:0] value,
	input wire logic last_word,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [15:0] data,
	output logic last_of_run
);

	// Front end to queue.
	logic push;
	rmaw_pkg::op_t front_op;
	logic q_full;

	// Queue to back end.
	logic q_vld;
	logic q_pop;
	rmaw_pkg::op_t q_op;

	// The front end classifies each transfer: it settles update addresses and the table
	// and range of a read, and drops the unused command without a result.
	rmaw_front #(
		.INPUT_COUNT(INPUT_COUNT),
		.HOLDING_COUNT(HOLDING_COUNT)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.table_sel(table_sel),
		.address(address),
		.count(count),
		.value(value),
		.last_word(last_word),
		.q_full(q_full),
		.push(push),
		.op(front_op)
	);

	// The queue decouples the two sides, so each can stall on its own.
	rmaw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(front_op),
		.full(q_full),
		.pop(q_pop),
		.vld(q_vld),
		.dout(q_op)
	);

	// The back end owns the stores and the burst state, runs reads word by word, and
	// commits a checked burst to the holding store with a sweep.
	rmaw_back #(
		.INPUT_COUNT(INPUT_COUNT),
		.HOLDING_COUNT(HOLDING_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_vld(q_vld),
		.q_op(q_op),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data(data),
		.last_of_run(last_of_run)
	);

endmodule

`default_nettype wire

[rtl/rmaw_front.sv]
`default_nettype none

module rmaw_front #(
	parameter int INPUT_COUNT = rmaw_pkg::INPUT_COUNT_DEF,
	parameter int HOLDING_COUNT = rmaw_pkg::HOLDING_COUNT_DEF
) (
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] command,
	input wire logic [1:0] table_sel,
	input wire logic [15:0] address,
	input wire logic [15:0] count,
	input wire logic [15:0] value,
	input wire logic last_word,
	input wire logic q_full,
	output logic push,
	output rmaw_pkg::op_t op
);

	logic [16:0] total;
	logic [16:0] range_end;
	logic range_ok;
	logic cmd_ok;

	always_comb begin
		total = (table_sel == rmaw_pkg::TBL_HOLDING) ? 17'(HOLDING_COUNT) : 17'(INPUT_COUNT);
		range_end = {1'b0, address} + {1'b0, count};
		range_ok = (count != 16'd0) && ({1'b0, address} < total) && (range_end <= total);

		op.kind = rmaw_pkg::OP_STATUS;
		op.status = rmaw_pkg::ST_OK;
		op.holding = (table_sel == rmaw_pkg::TBL_HOLDING);
		op.address = address;
		op.count = count;
		op.value = value;
		op.last = last_word;
		cmd_ok = 1'b1;

		case (command)
			rmaw_pkg::CMD_UPDATE: begin
				if (address < 16'(INPUT_COUNT)) begin
					op.kind = rmaw_pkg::OP_UPDATE;
				end else begin
					op.status = rmaw_pkg::ST_BAD_ADDR;
				end
			end
			rmaw_pkg::CMD_READ: begin
				if (!(table_sel inside {rmaw_pkg::TBL_INPUT, rmaw_pkg::TBL_HOLDING})) begin
					op.status = rmaw_pkg::ST_BAD_TABLE;
				end else if (!range_ok) begin
					op.status = rmaw_pkg::ST_BAD_ADDR;
				end else begin
					op.kind = rmaw_pkg::OP_READ;
				end
			end
			rmaw_pkg::CMD_WRITE: begin
				op.kind = rmaw_pkg::OP_BURST;
			end
			default: begin
				// The unused command is dropped here and never reaches the queue.
				cmd_ok = 1'b0;
			end
		endcase
	end

	assign in_stall = q_full;
	assign push = in_valid && !q_full && cmd_ok;

endmodule

`default_nettype wire

[rtl/rmaw_queue.sv]
`default_nettype none

module rmaw_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire rmaw_pkg::op_t din,
	output logic full,
	input wire logic pop,
	output logic vld,
	output rmaw_pkg::op_t dout
);

	localparam int DEPTH = rmaw_pkg::QUEUE_DEPTH;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	rmaw_pkg::op_t slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CNTW'(DEPTH));
	assign vld = (cnt_q != '0);
	assign dout = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

[rtl/rmaw_back.sv]
`default_nettype none

`include "register_map_with_atomic_write_top_assert.svh"

module rmaw_back #(
	parameter int INPUT_COUNT = rmaw_pkg::INPUT_COUNT_DEF,
	parameter int HOLDING_COUNT = rmaw_pkg::HOLDING_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_vld,
	input wire rmaw_pkg::op_t q_op,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [15:0] data,
	output logic last_of_run
);

	localparam int IN_AW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
	localparam int HD_AW = $clog2(HOLDING_COUNT);
	localparam int MAXN = (INPUT_COUNT > HOLDING_COUNT) ? INPUT_COUNT : HOLDING_COUNT;
	localparam int PW = $clog2(MAXN);
	localparam int CW = $clog2(MAXN + 1);
	localparam int SW = $clog2(HOLDING_COUNT + 1);
	localparam logic [16:0] FLAG_WORD_ADDR = 17'd3;
	localparam logic [15:0] FLAG_WORD_MAX = 16'd1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD_ISSUE = 4'b0010,
		S_RD_EMIT = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q;

	// Result register.
	logic res_vld_q;
	rmaw_pkg::status_t res_status_q;
	logic [15:0] res_data_q;
	logic res_last_q;

	// Read run.
	logic tbl_q;
	logic [PW-1:0] ptr_q;
	logic [CW-1:0] rem_q;

	// Burst bookkeeping.
	logic [15:0] bwc_q;
	logic [15:0] bstart_q;
	logic [15:0] blen_q;
	logic bbad_q;

	// Commit sweep.
	logic [SW-1:0] ck_q;
	logic [SW-1:0] clen_q;
	logic wpend_s1;
	logic [HD_AW-1:0] waddr_s1;

	// Stores and their read registers.
	logic [15:0] in_mem [INPUT_COUNT];
	logic [15:0] hold_mem [HOLDING_COUNT];
	logic [15:0] stg_mem [HOLDING_COUNT];
	logic in_vld_q [INPUT_COUNT];
	logic hold_vld_q [HOLDING_COUNT];
	logic [15:0] in_rd_q;
	logic in_rd_vld_q;
	logic [15:0] hold_rd_q;
	logic hold_rd_vld_q;
	logic hold_rd_w0_q;
	logic [15:0] stg_rd_q;

	logic out_free;
	logic take;
	logic rd_issue;
	logic cm_issue;
	logic stg_we;
	logic first;
	logic [15:0] bstart_n;
	logic [15:0] blen_n;
	logic [16:0] chk_addr;
	logic word_bad;
	logic bad_n;
	logic [16:0] nwords;
	logic [16:0] bend;
	logic brange_ok;
	rmaw_pkg::status_t bstat;
	logic [15:0] in_word;
	logic [15:0] hold_word;
	logic emit;
	rmaw_pkg::status_t emit_status;
	logic [15:0] emit_data;
	logic emit_last;

	assign out_free = !res_vld_q || !out_stall;
	assign take = (state_q == S_IDLE) && q_vld && out_free;
	assign q_pop = take;
	assign rd_issue = (state_q == S_RD_ISSUE);
	assign cm_issue = (state_q == S_COMMIT) && (ck_q != clen_q);
	assign stg_we = take && (q_op.kind == rmaw_pkg::OP_BURST) &&
		(bwc_q < 16'(HOLDING_COUNT));

	// Burst word checks: the first word of a burst latches start and length.
	always_comb begin
		first = (bwc_q == 16'd0);
		bstart_n = first ? q_op.address : bstart_q;
		blen_n = first ? q_op.count : blen_q;
		chk_addr = {1'b0, bstart_n} + {1'b0, bwc_q};
		word_bad = ((chk_addr == 17'd0) && (q_op.value == 16'd0)) ||
			((chk_addr == FLAG_WORD_ADDR) && (q_op.value > FLAG_WORD_MAX));
		bad_n = (!first && bbad_q) || word_bad;
		nwords = {1'b0, bwc_q} + 17'd1;
		bend = {1'b0, bstart_n} + {1'b0, blen_n};
		brange_ok = (blen_n != 16'd0) && (bstart_n < 16'(HOLDING_COUNT)) &&
			(bend <= 17'(HOLDING_COUNT));
		if ((nwords != {1'b0, blen_n}) || !brange_ok) begin
			bstat = rmaw_pkg::ST_BAD_ADDR;
		end else if (bad_n) begin
			bstat = rmaw_pkg::ST_BAD_VALUE;
		end else begin
			bstat = rmaw_pkg::ST_OK;
		end
	end

	assign in_word = in_rd_vld_q ? in_rd_q : 16'd0;
	assign hold_word = hold_rd_vld_q ? hold_rd_q :
		(hold_rd_w0_q ? rmaw_pkg::HOLD_WORD0_RESET : 16'd0);

	always_comb begin
		emit = 1'b0;
		emit_status = rmaw_pkg::ST_OK;
		emit_data = 16'd0;
		emit_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (q_op.kind)
						rmaw_pkg::OP_UPDATE: begin
							emit = 1'b1;
						end
						rmaw_pkg::OP_STATUS: begin
							emit = 1'b1;
							emit_status = q_op.status;
						end
						rmaw_pkg::OP_BURST: begin
							emit = q_op.last && (bstat != rmaw_pkg::ST_OK);
							emit_status = bstat;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_RD_EMIT: begin
				emit = out_free;
				emit_data = tbl_q ? hold_word : in_word;
				emit_last = (rem_q == CW'(1));
			end
			S_COMMIT: begin
				emit = (ck_q == clen_q) && !wpend_s1 && out_free;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_vld_q <= 1'b0;
			tbl_q <= 1'b0;
			ptr_q <= '0;
			rem_q <= '0;
			bwc_q <= 16'd0;
			bstart_q <= 16'd0;
			blen_q <= 16'd0;
			bbad_q <= 1'b0;
			ck_q <= '0;
			clen_q <= '0;
			wpend_s1 <= 1'b0;
			for (int i = 0; i < INPUT_COUNT; i++) begin
				in_vld_q[i] <= 1'b0;
			end
			for (int i = 0; i < HOLDING_COUNT; i++) begin
				hold_vld_q[i] <= 1'b0;
			end
		end else begin
			if (emit) begin
				res_vld_q <= 1'b1;
			end else if (!out_stall) begin
				res_vld_q <= 1'b0;
			end
			wpend_s1 <= cm_issue;
			if (wpend_s1) begin
				hold_vld_q[waddr_s1] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (q_op.kind)
							rmaw_pkg::OP_UPDATE: begin
								in_vld_q[q_op.address[IN_AW-1:0]] <= 1'b1;
							end
							rmaw_pkg::OP_READ: begin
								tbl_q <= q_op.holding;
								ptr_q <= q_op.address[PW-1:0];
								rem_q <= q_op.count[CW-1:0];
								state_q <= S_RD_ISSUE;
							end
							rmaw_pkg::OP_BURST: begin
								bstart_q <= bstart_n;
								blen_q <= blen_n;
								if (q_op.last) begin
									bwc_q <= 16'd0;
									bbad_q <= 1'b0;
									if (bstat == rmaw_pkg::ST_OK) begin
										ck_q <= '0;
										clen_q <= blen_n[SW-1:0];
										state_q <= S_COMMIT;
									end
								end else begin
									bbad_q <= bad_n;
									if (bwc_q != 16'hFFFF) begin
										bwc_q <= bwc_q + 16'd1;
									end
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (out_free) begin
						ptr_q <= ptr_q + PW'(1);
						rem_q <= rem_q - CW'(1);
						state_q <= (rem_q == CW'(1)) ? S_IDLE : S_RD_ISSUE;
					end
				end
				S_COMMIT: begin
					if (cm_issue) begin
						ck_q <= ck_q + SW'(1);
					end
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q <= emit_status;
			res_data_q <= emit_data;
			res_last_q <= emit_last;
		end
		if (cm_issue) begin
			waddr_s1 <= bstart_q[HD_AW-1:0] + ck_q[HD_AW-1:0];
		end
	end

	// Input store: written by updates, read one word per step of a read run.
	always_ff @(posedge clk) begin
		if (take && (q_op.kind == rmaw_pkg::OP_UPDATE)) begin
			in_mem[q_op.address[IN_AW-1:0]] <= q_op.value;
		end
		if (rd_issue && !tbl_q) begin
			in_rd_q <= in_mem[ptr_q[IN_AW-1:0]];
			in_rd_vld_q <= in_vld_q[ptr_q[IN_AW-1:0]];
		end
	end

	// Holding store: written only by the commit sweep.
	always_ff @(posedge clk) begin
		if (wpend_s1) begin
			hold_mem[waddr_s1] <= stg_rd_q;
		end
		if (rd_issue && tbl_q) begin
			hold_rd_q <= hold_mem[ptr_q[HD_AW-1:0]];
			hold_rd_vld_q <= hold_vld_q[ptr_q[HD_AW-1:0]];
			hold_rd_w0_q <= (ptr_q == '0);
		end
	end

	// Staging buffer for burst words.
	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_mem[bwc_q[HD_AW-1:0]] <= q_op.value;
		end
		if (cm_issue) begin
			stg_rd_q <= stg_mem[ck_q[HD_AW-1:0]];
		end
	end

	assign out_valid = res_vld_q;
	assign status = res_status_q;
	assign data = res_data_q;
	assign last_of_run = res_last_q;

	`RMAW_ASSERT_IMP(a_emit_rem_nonzero, state_q == S_RD_EMIT, rem_q != '0, "read run has no words left")
	`RMAW_ASSERT_IMP(a_pop_only_idle, q_pop, state_q == S_IDLE, "queue popped while busy")
	`RMAW_ASSERT_NEXT(a_run_end_idle, (state_q == S_RD_EMIT) && emit && (rem_q == CW'(1)), state_q == S_IDLE, "read run did not end")
	`RMAW_ASSERT_NEXT(a_burst_end_clears, q_pop && (q_op.kind == rmaw_pkg::OP_BURST) && q_op.last, (bwc_q == 16'd0) && !bbad_q, "burst state not cleared")
	`RMAW_ASSERT_IMP(a_commit_bound, state_q == S_COMMIT, ck_q <= clen_q, "commit sweep overran")

endmodule

`default_nettype wire

[bench/register_map_with_atomic_write_top_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the register map with atomic holding writes.
// Input updates, range reads and holding write bursts go in through the input channel.
// A scoreboard in this module follows the two register files and the burst staging state.
// It queues the words each accepted transfer should produce.
// Every word that leaves the output channel is checked against the oldest queued word.
module register_map_with_atomic_write_top_tb;
	import rmaw_pkg::*;

	localparam int NUM_INPUT = INPUT_COUNT_DEF;
	localparam int NUM_HOLDING = HOLDING_COUNT_DEF;
	// Holding word 3 is a flag: only 0 or 1 may be written to it.
	localparam int FLAG_WORD = 3;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] TBL_SPARE_LO = 2'd2;
	localparam logic [1:0] TBL_SPARE_HI = 2'd3;
	localparam int DIRECTED_ROWS = 25;
	localparam int NUM_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 84;
	// This covers both a full read and a full commit.
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] tsel;
		logic [15:0] addr;
		logic [15:0] cnt;
		logic [15:0] val;
		logic fin;
	} access_t;

	typedef struct {
		status_t st;
		logic [15:0] word;
		logic fin;
	} result_t;

	// One row of the directed table. Where hand_checked is set, the single result is given
	// in the row itself. The other rows are left to the scoreboard.
	typedef struct {
		logic [1:0] cmd;
		logic [1:0] tsel;
		logic [15:0] addr;
		logic [15:0] cnt;
		logic [15:0] val;
		logic fin;
		bit hand_checked;
		status_t st;
		logic [15:0] word;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic [1:0] table_sel = '0;
	logic [15:0] address = '0;
	logic [15:0] count = '0;
	logic [15:0] value = '0;
	logic last_word = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [15:0] data;
	logic last_of_run;

	// Scoreboard copy of the block state.
	logic [15:0] input_regs [NUM_INPUT];
	logic [15:0] holding_regs [NUM_HOLDING];
	logic [15:0] staged_words [NUM_HOLDING];
	logic [15:0] burst_words;
	logic [15:0] burst_base;
	logic [15:0] burst_len;
	logic burst_bad;

	result_t predicted_results [$];
	result_t pending_results [$];
	int error_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int phase_idle_pct [NUM_PHASES] = '{0, 79, 0, 22, 0};
	int phase_stall_pct [NUM_PHASES] = '{0, 0, 79, 22, 0};

	// The directed table covers these cases in order:
	// - the reset contents;
	// - both bad table codes;
	// - every kind of bad read range, including the one that would overflow 16 bits;
	// - updates at both ends of the input file and past it;
	// - the unused command;
	// - a full good burst and its read back;
	// - a zero in word 0 and an out-of-range flag word;
	// - a burst range that leaves the holding file;
	// - a burst that is shorter than its count;
	// - a single good flag write.
	directed_row_t directed [DIRECTED_ROWS] = '{
		'{CMD_READ, TBL_HOLDING, 16'd0, 16'd1, 16'd0, 1'b0, 1'b1, ST_OK, 16'd1000},
		'{CMD_READ, TBL_INPUT, 16'd11, 16'd1, 16'd0, 1'b0, 1'b1, ST_OK, 16'd0},
		'{CMD_READ, TBL_SPARE_LO, 16'd0, 16'd1, 16'd0, 1'b0, 1'b1, ST_BAD_TABLE, 16'd0},
		'{CMD_READ, TBL_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, ST_BAD_TABLE,
			16'd0},
		'{CMD_READ, TBL_INPUT, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, ST_BAD_ADDR, 16'd0},
		'{CMD_READ, TBL_INPUT, 16'd12, 16'd1, 16'd0, 1'b0, 1'b1, ST_BAD_ADDR, 16'd0},
		'{CMD_READ, TBL_INPUT, 16'd0, 16'd13, 16'd0, 1'b0, 1'b1, ST_BAD_ADDR, 16'd0},
		'{CMD_READ, TBL_INPUT, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 1'b1, ST_BAD_ADDR, 16'd0},
		'{CMD_UPDATE, TBL_INPUT, 16'd0, 16'd0, 16'hFFFF, 1'b0, 1'b1, ST_OK, 16'd0},
		'{CMD_UPDATE, TBL_INPUT, 16'd11, 16'd0, 16'hA5A5, 1'b0, 1'b1, ST_OK, 16'd0},
		'{CMD_UPDATE, TBL_INPUT, 16'd12, 16'd0, 16'h1234, 1'b0, 1'b1, ST_BAD_ADDR, 16'd0},
		'{CMD_UPDATE, TBL_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, ST_BAD_ADDR,
			16'd0},
		'{CMD_READ, TBL_INPUT, 16'd0, 16'd12, 16'd0, 1'b0, 1'b0, ST_OK, 16'd0},
		'{CMD_UNUSED, TBL_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, ST_OK, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'd0, 16'd4, 16'd1, 1'b0, 1'b0, ST_OK, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'hFFFF, 16'hFFFF, 16'd2, 1'b0, 1'b0, ST_OK, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'hFFFF, 16'hFFFF, 16'd3, 1'b0, 1'b0, ST_OK, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'hFFFF, 16'hFFFF, 16'd1, 1'b1, 1'b0, ST_OK, 16'd0},
		'{CMD_READ, TBL_HOLDING, 16'd0, 16'd4, 16'd0, 1'b0, 1'b0, ST_OK, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'd0, 16'd1, 16'd0, 1'b1, 1'b1, ST_BAD_VALUE, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'd3, 16'd1, 16'd2, 1'b1, 1'b1, ST_BAD_VALUE, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'd2, 16'd3, 16'd5, 1'b1, 1'b1, ST_BAD_ADDR, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'd0, 16'd2, 16'd7, 1'b1, 1'b1, ST_BAD_ADDR, 16'd0},
		'{CMD_WRITE, TBL_INPUT, 16'd3, 16'd1, 16'd1, 1'b1, 1'b1, ST_OK, 16'd0},
		'{CMD_READ, TBL_HOLDING, 16'd3, 16'd1, 16'd0, 1'b0, 1'b1, ST_OK, 16'd1}
	};

	register_map_with_atomic_write_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.table_sel(table_sel),
		.address(address),
		.count(count),
		.value(value),
		.last_word(last_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data(data),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The range check is done in 32 bits, so a start and a length near 65535 cannot wrap.
	function automatic bit span_fits(int unsigned start, int unsigned len, int unsigned total);
		return len != 0 && start < total && len <= total - start;
	endfunction

	// Applies one accepted transfer to the scoreboard state.
	// It leaves the words that the transfer should produce in predicted_results.
	function automatic void predict_access(access_t a);
		int unsigned total;
		int unsigned idx;
		int unsigned n;
		int unsigned target;
		status_t st;
		predicted_results.delete();
		case (a.cmd)
			CMD_UPDATE: begin
				if (a.addr >= NUM_INPUT) begin
					predicted_results.push_back('{ST_BAD_ADDR, 16'd0, 1'b1});
				end else begin
					input_regs[a.addr] = a.val;
					predicted_results.push_back('{ST_OK, 16'd0, 1'b1});
				end
			end
			CMD_READ: begin
				if (a.tsel != TBL_INPUT && a.tsel != TBL_HOLDING) begin
					predicted_results.push_back('{ST_BAD_TABLE, 16'd0, 1'b1});
				end else begin
					total = (a.tsel == TBL_INPUT) ? NUM_INPUT : NUM_HOLDING;
					if (!span_fits(a.addr, a.cnt, total)) begin
						predicted_results.push_back('{ST_BAD_ADDR, 16'd0, 1'b1});
					end else begin
						for (int unsigned i = 0; i < a.cnt; i++) begin
							predicted_results.push_back('{ST_OK,
								(a.tsel == TBL_INPUT) ? input_regs[a.addr + i] :
								holding_regs[a.addr + i], i + 1 == a.cnt});
						end
					end
				end
			end
			CMD_WRITE: begin
				// The first word of a burst latches the range; later words only carry data.
				if (burst_words == 0) begin
					burst_base = a.addr;
					burst_len = a.cnt;
					burst_bad = 1'b0;
				end
				idx = burst_words;
				if (idx < NUM_HOLDING)
					staged_words[idx] = a.val;
				target = burst_base + idx;
				if ((target == 0 && a.val == 0) || (target == FLAG_WORD && a.val > 1))
					burst_bad = 1'b1;
				n = idx + 1;
				if (burst_words != 16'hFFFF)
					burst_words = burst_words + 16'd1;
				if (a.fin) begin
					if (n != burst_len || !span_fits(burst_base, burst_len, NUM_HOLDING)) begin
						st = ST_BAD_ADDR;
					end else if (burst_bad) begin
						st = ST_BAD_VALUE;
					end else begin
						for (int unsigned i = 0; i < n; i++)
							holding_regs[burst_base + i] = staged_words[i];
						st = ST_OK;
					end
					burst_words = '0;
					burst_bad = 1'b0;
					predicted_results.push_back('{st, 16'd0, 1'b1});
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Presents one transfer after a random number of idle cycles and holds it until it is
	// taken. Inputs change only at the falling edge, and in_stall is looked at on the rising
	// edge. A row that is checked by hand queues its own expected word in place of the
	// scoreboard's.
	task automatic drive_access(input access_t a, input bit hand_checked, input result_t hand_res);
		bit idle;
		idle = 1'b1;
		while (idle) begin
			@(negedge clk);
			idle = $urandom_range(99) < sender_idle_pct;
			if (idle)
				in_valid <= 1'b0;
		end
		command <= a.cmd;
		table_sel <= a.tsel;
		address <= a.addr;
		count <= a.cnt;
		value <= a.val;
		last_word <= a.fin;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_access(a);
		if (hand_checked) begin
			pending_results.push_back(hand_res);
		end else begin
			foreach (predicted_results[i])
				pending_results.push_back(predicted_results[i]);
		end
	endtask

	// Sends one random transaction. Most of the traffic is well formed: updates inside the
	// input file, reads that fit their table, and bursts with the right length and legal
	// data. The rest is out of range, corrupt, or uses the unused command. Transfers of the
	// unused command are not counted.
	task automatic send_random_traffic(output int counted);
		access_t a;
		int kind;
		int unsigned total;
		int unsigned start;
		int unsigned len;
		int unsigned words;
		int unsigned target;
		counted = 0;
		kind = $urandom_range(99);
		a.cmd = CMD_UNUSED;
		a.tsel = 2'($urandom);
		a.addr = 16'($urandom);
		a.cnt = 16'($urandom);
		a.val = 16'($urandom);
		a.fin = 1'($urandom);
		if (kind < 20) begin
			a.cmd = CMD_UPDATE;
			if ($urandom_range(9) != 0)
				a.addr = 16'($urandom_range(NUM_INPUT - 1));
			drive_access(a, 1'b0, '{ST_OK, 16'd0, 1'b0});
			counted = 1;
		end else if (kind < 50) begin
			a.cmd = CMD_READ;
			if ($urandom_range(9) != 0)
				a.tsel = 2'($urandom_range(1));
			total = (a.tsel == TBL_HOLDING) ? NUM_HOLDING : NUM_INPUT;
			if ($urandom_range(7) != 0) begin
				a.addr = 16'($urandom_range(total - 1));
				a.cnt = 16'($urandom_range(total - a.addr, 1));
			end
			drive_access(a, 1'b0, '{ST_OK, 16'd0, 1'b0});
			counted = 1;
		end else if (kind < 95) begin
			start = ($urandom_range(9) == 0) ? $urandom_range(65535) :
				$urandom_range(NUM_HOLDING - 1);
			len = (start < NUM_HOLDING) ? $urandom_range(NUM_HOLDING - start, 1) :
				$urandom_range(NUM_HOLDING, 1);
			// Now and then the burst is cut short or runs past the holding file.
			words = ($urandom_range(5) == 0) ? $urandom_range(6, 1) : len;
			for (int unsigned w = 0; w < words; w++) begin
				if ($urandom_range(11) == 0) begin
					a.cmd = CMD_UNUSED;
					a.val = 16'($urandom);
					drive_access(a, 1'b0, '{ST_OK, 16'd0, 1'b0});
				end
				a.cmd = CMD_WRITE;
				a.tsel = 2'($urandom);
				a.addr = (w == 0) ? 16'(start) : 16'($urandom);
				a.cnt = (w == 0 && $urandom_range(9) != 0) ? 16'(len) : 16'($urandom);
				target = start + w;
				if ($urandom_range(7) == 0)
					a.val = 16'($urandom);
				else if (target == 0)
					a.val = 16'($urandom_range(65535, 1));
				else if (target == FLAG_WORD)
					a.val = 16'($urandom_range(1));
				else
					a.val = 16'($urandom);
				a.fin = (w + 1 == words);
				drive_access(a, 1'b0, '{ST_OK, 16'd0, 1'b0});
				counted++;
			end
		end else begin
			drive_access(a, 1'b0, '{ST_OK, 16'd0, 1'b0});
		end
	endtask

	// The stall on the output side is redrawn at every falling edge.
	always @(negedge clk)
		out_stall <= $urandom_range(99) < receiver_stall_pct;

	// Scoreboard check. A word is taken at a rising edge with out_valid high and out_stall
	// low.
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d data %h last %b",
					$time, status, data, last_of_run);
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.st) begin
					$display("%0t: status expected %0d, got %0d", $time, exp_res.st, status);
					error_count++;
				end
				if (data !== exp_res.word) begin
					$display("%0t: data expected %h, got %h", $time, exp_res.word, data);
					error_count++;
				end
				if (last_of_run !== exp_res.fin) begin
					$display("%0t: last_of_run expected %b, got %b",
						$time, exp_res.fin, last_of_run);
					error_count++;
				end
			end
		end
	end

	// Timeout. The limit is many times the slowest legal run: every read at full length and
	// every word waiting out long stalls on the output side.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("register_map_with_atomic_write_top test failed");
		$finish;
	end

	initial begin
		int sent;
		int n;
		access_t a;
		foreach (input_regs[i])
			input_regs[i] = '0;
		foreach (holding_regs[i])
			holding_regs[i] = '0;
		holding_regs[0] = HOLD_WORD0_RESET;
		burst_words = '0;
		burst_base = '0;
		burst_len = '0;
		burst_bad = 1'b0;

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The directed table is sent with no idling on either side.
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			a.cmd = directed[r].cmd;
			a.tsel = directed[r].tsel;
			a.addr = directed[r].addr;
			a.cnt = directed[r].cnt;
			a.val = directed[r].val;
			a.fin = directed[r].fin;
			drive_access(a, directed[r].hand_checked,
				'{directed[r].st, directed[r].word, 1'b1});
		end

		// Each random phase has its own idle and stall rates.
		// Between phases the sender holds off until every queued word has come out.
		for (int p = 0; p < NUM_PHASES; p++) begin
			@(negedge clk);
			in_valid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
			sender_idle_pct = phase_idle_pct[p];
			receiver_stall_pct = phase_stall_pct[p];
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				send_random_traffic(n);
				sent += n;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("register_map_with_atomic_write_top test passed");
		else
			$display("register_map_with_atomic_write_top test failed");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/rmaw_pkg.sv
rtl/rmaw_front.sv
rtl/rmaw_queue.sv
rtl/rmaw_back.sv
rtl/register_map_with_atomic_write_top.sv
bench/register_map_with_atomic_write_top_tb.sv
